// File: design/csef_pkg.sv
// csef_pkg: shared constants, register codes and window control type
// for the combined sobel edge filter. no dependencies.
`default_nettype none

package csef_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int CHANNEL_BITS   = 8;
  localparam int CFG_BITS       = 12;
  localparam int CFG_INDEX_BITS = 1;
  localparam int ROW_BITS       = 12;
  localparam int HEIGHT_LIMIT   = 2048;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // emit and frame end flags and which neighbors lie inside the frame
  typedef struct packed {
    logic emit;
    logic left;
    logic right;
    logic top;
    logic bottom;
    logic frame_end;
  } win_ctl_t;

endpackage

`default_nettype wire

// File: design/csef_in_if.sv
// csef_in_if: valid/ready pixel request channel into the edge filter.
// depends on csef_pkg for the default channel width.
`default_nettype none

interface csef_in_if #(
  parameter int CHANNEL_BITS = csef_pkg::CHANNEL_BITS
) ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_in;
  logic [CHANNEL_BITS-1:0] green_in;
  logic [CHANNEL_BITS-1:0] blue_in;
  logic                    pad;

  modport source (output valid, red_in, green_in, blue_in, pad, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, pad, output ready);
endinterface

`default_nettype wire

// File: design/csef_out_if.sv
// csef_out_if: valid/ready result request channel out of the edge filter.
// depends on csef_pkg for the default channel width.
`default_nettype none

interface csef_out_if #(
  parameter int CHANNEL_BITS = csef_pkg::CHANNEL_BITS
) ();
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_out;
  logic [CHANNEL_BITS-1:0] green_out;
  logic [CHANNEL_BITS-1:0] blue_out;
  logic                    frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

`default_nettype wire

// File: design/csef_ram.sv
// csef_ram: generic single write port, single read port ram with
// registered read data. no dependencies.
`default_nettype none

module csef_ram #(
  parameter  int WIDTH  = 24,
  parameter  int DEPTH  = 2048,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/csef_position.sv
// csef_position: configuration registers and raster position counters,
// derives the window control for each incoming request. uses csef_pkg.
`default_nettype none

module csef_position #(
  parameter  int MAX_WIDTH = csef_pkg::MAX_WIDTH,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 wr_en,
  input  wire logic [csef_pkg::CFG_INDEX_BITS-1:0]  wr_index,
  input  wire logic [csef_pkg::CFG_BITS-1:0]        wr_data,
  input  wire logic                                 accept,
  output      csef_pkg::win_ctl_t                   ctl,
  output      logic [COL_W-1:0]                     column
);

  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = csef_pkg::ROW_BITS;

  logic [csef_pkg::CFG_BITS-1:0] image_width;
  logic [csef_pkg::CFG_BITS-1:0] image_height;
  logic [WID_W-1:0]              w;
  logic [ROW_W-1:0]              h;
  logic [ROW_W-1:0]              h_pad;
  logic [COL_W-1:0]              col;
  logic [COL_W-1:0]              col_next;
  logic [COL_W-1:0]              cx;
  logic [ROW_W-1:0]              row;
  logic [ROW_W-1:0]              row_next;
  logic [ROW_W-1:0]              row_fix;
  logic [ROW_W-1:0]              cy;
  logic                          first;
  logic                          second;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= csef_pkg::CFG_BITS'(csef_pkg::WIDTH_RESET);
      image_height <= csef_pkg::CFG_BITS'(csef_pkg::HEIGHT_RESET);
    end else if (wr_en) begin
      case (csef_pkg::cfg_reg_t'(wr_index))
        csef_pkg::REG_IMAGE_WIDTH:  image_width  <= wr_data;
        csef_pkg::REG_IMAGE_HEIGHT: image_height <= wr_data;
        default: ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    if (image_width == '0) begin
      w = WID_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w = WID_W'(MAX_WIDTH);
    end else begin
      w = WID_W'(image_width);
    end
    if (image_height == '0) begin
      h = ROW_W'(1);
    end else if (32'(image_height) > 32'(csef_pkg::HEIGHT_LIMIT)) begin
      h = ROW_W'(csef_pkg::HEIGHT_LIMIT);
    end else begin
      h = ROW_W'(image_height);
    end
    h_pad = h + ROW_W'(1);
  end

  // position of the arriving request
  always_comb begin
    cx      = col;
    row_fix = row;
    if (WID_W'(col) >= w) begin
      cx      = '0;
      row_fix = row + ROW_W'(1);
    end
    cy = row_fix;
    if (row_fix > h_pad) begin
      cy = '0;
    end
  end

  always_comb begin
    first  = (cx == '0) && (cy >= ROW_W'(2));
    second = (cx != '0) && (cy >= ROW_W'(1)) && (cy <= h);
    ctl.emit      = first || second;
    ctl.left      = first ? (w >= WID_W'(2)) : (cx >= COL_W'(2));
    ctl.right     = second;
    ctl.top       = first ? (cy >= ROW_W'(3)) : (cy >= ROW_W'(2));
    ctl.bottom    = first ? (cy <= h) : (cy < h);
    ctl.frame_end = first && (cy == h_pad);
    column        = cx;
  end

  always_comb begin
    if ((WID_W'(cx) + WID_W'(1)) >= w) begin
      col_next = '0;
      row_next = cy + ROW_W'(1);
    end else begin
      col_next = COL_W'(WID_W'(cx) + WID_W'(1));
      row_next = cy;
    end
    if ((cx == '0) && (cy == h_pad)) begin
      col_next = '0;
      row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && ctl.frame_end |=> (col == '0) && (row == '0))
    else $error("position did not wrap after frame end");

  a_frame_end_ctl: assert property (@(posedge clk) disable iff (rst)
    ctl.frame_end |-> ctl.emit && !ctl.right)
    else $error("frame end without last column window");

  a_right_col: assert property (@(posedge clk) disable iff (rst)
    ctl.right |-> ctl.emit && (column != '0))
    else $error("right neighbor flagged at column zero");

endmodule

`default_nettype wire

// File: design/csef_datapath.sv
// csef_datapath: line stores, 3x3 window, combined kernel and output
// register. uses csef_pkg, csef_in_if, csef_out_if and csef_ram.
`default_nettype none

module csef_datapath #(
  parameter  int MAX_WIDTH    = csef_pkg::MAX_WIDTH,
  parameter  int CHANNEL_BITS = csef_pkg::CHANNEL_BITS,
  localparam int COL_W        = $clog2(MAX_WIDTH)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  csef_in_if.sink                 pixels,
  csef_out_if.source              edges,
  input  wire csef_pkg::win_ctl_t ctl,
  input  wire logic [COL_W-1:0]   column,
  output      logic               accept
);

  localparam int CB    = CHANNEL_BITS;
  localparam int PIX_W = 3 * CB;
  localparam int HALF  = (1 << (CB - 1)) - 1;

  logic               s1_valid;
  logic               s1_go;
  logic               s1_hit;
  csef_pkg::win_ctl_t s1_ctl;
  logic [COL_W-1:0]   s1_addr;
  logic [PIX_W-1:0]   s1_px;
  logic [PIX_W-1:0]   s1_byp_near;
  logic [PIX_W-1:0]   s1_byp_far;
  logic [PIX_W-1:0]   px_in;
  logic [PIX_W-1:0]   near_q;
  logic [PIX_W-1:0]   far_q;
  logic [PIX_W-1:0]   near;
  logic [PIX_W-1:0]   far;
  logic [PIX_W-1:0]   win_left   [3];
  logic [PIX_W-1:0]   win_center [3];
  logic [PIX_W-1:0]   win_new    [3];
  logic [CB-1:0]      res        [3];

  assign s1_go        = s1_valid && (!edges.valid || edges.ready);
  assign pixels.ready = !s1_valid || s1_go;
  assign accept       = pixels.valid && pixels.ready;
  assign px_in        = pixels.pad ? '0 : {pixels.blue_in, pixels.green_in, pixels.red_in};

  // row above and two rows above
  csef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_near (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_addr),
    .wr_data (s1_px),
    .rd_en   (accept),
    .rd_addr (column),
    .rd_data (near_q)
  );

  csef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_far (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_addr),
    .wr_data (near),
    .rd_en   (accept),
    .rd_addr (column),
    .rd_data (far_q)
  );

  // same column written while read: take the written data
  assign near = s1_hit ? s1_byp_near : near_q;
  assign far  = s1_hit ? s1_byp_far  : far_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px       <= px_in;
      s1_ctl      <= ctl;
      s1_addr     <= column;
      s1_hit      <= s1_go && (s1_addr == column);
      s1_byp_near <= s1_px;
      s1_byp_far  <= near;
    end
  end

  assign win_new[0] = far;
  assign win_new[1] = near;
  assign win_new[2] = s1_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_left[i]   <= '0;
        win_center[i] <= '0;
      end
    end else if (s1_go) begin
      for (int i = 0; i < 3; i++) begin
        win_left[i]   <= win_center[i];
        win_center[i] <= win_new[i];
      end
    end
  end

  // weight +2 below/right, -2 above/left, 0 on the anti-diagonal
  for (genvar k = 0; k < 3; k++) begin : g_chan
    logic [CB+1:0]        pos;
    logic [CB+1:0]        neg;
    logic signed [CB+2:0] diff;

    always_comb begin
      pos = (s1_ctl.right ? (CB+2)'(win_new[1][k*CB +: CB]) : '0)
          + (s1_ctl.bottom ? (CB+2)'(win_center[2][k*CB +: CB]) : '0)
          + ((s1_ctl.right && s1_ctl.bottom) ? (CB+2)'(win_new[2][k*CB +: CB]) : '0);
      neg = (s1_ctl.left ? (CB+2)'(win_left[1][k*CB +: CB]) : '0)
          + (s1_ctl.top ? (CB+2)'(win_center[0][k*CB +: CB]) : '0)
          + ((s1_ctl.left && s1_ctl.top) ? (CB+2)'(win_left[0][k*CB +: CB]) : '0);
      diff = $signed({1'b0, pos}) - $signed({1'b0, neg});
      if (diff < 0) begin
        res[k] = '0;
      end else if (diff > $signed((CB+3)'(HALF))) begin
        res[k] = '1;
      end else begin
        res[k] = {diff[CB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edges.valid <= 1'b0;
    end else if (s1_go) begin
      edges.valid <= s1_ctl.emit;
    end else if (edges.ready) begin
      edges.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_ctl.emit) begin
      edges.red_out   <= res[0];
      edges.green_out <= res[1];
      edges.blue_out  <= res[2];
      edges.frame_end <= s1_ctl.frame_end;
    end
  end

  a_s1_fill: assert property (@(posedge clk) disable iff (rst)
    accept && !s1_go |=> s1_valid)
    else $error("accepted request lost from stage one");

  a_emit_out: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_ctl.emit |=> edges.valid)
    else $error("window result not presented");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_addr))
    else $error("stalled stage one changed");

endmodule

`default_nettype wire

// File: design/combined_sobel_edge_filter.sv
// combined_sobel_edge_filter: streaming 3x3 combined sobel filter on rgb.
// the completing request passes stage one and the output register before the earliest
// result handshake; it belongs to the pixel width+1 requests earlier in raster order.
// throughput: one request per cycle unless the output stalls, set by one read and one
// write per line store ram. reset: synchronous, clears counters, window and handshakes,
// restores 640x480; the line stores are not cleared and need no clearing pass.
`default_nettype none

module combined_sobel_edge_filter #(
  parameter int MAX_WIDTH    = csef_pkg::MAX_WIDTH,
  parameter int CHANNEL_BITS = csef_pkg::CHANNEL_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                wr_en,
  input  wire logic [csef_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  wire logic [csef_pkg::CFG_BITS-1:0]       wr_data,
  csef_in_if.sink                                  pixels,
  csef_out_if.source                               edges
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  csef_pkg::win_ctl_t ctl;
  logic [COL_W-1:0]   column;
  logic               accept;

  csef_position #(.MAX_WIDTH(MAX_WIDTH)) u_position (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .accept   (accept),
    .ctl      (ctl),
    .column   (column)
  );

  csef_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels),
    .edges  (edges),
    .ctl    (ctl),
    .column (column),
    .accept (accept)
  );

endmodule

`default_nettype wire

// File: sim/tb_combined_sobel_edge_filter.sv
`timescale 1ns / 1ps
// tb_combined_sobel_edge_filter: self-checking bench, streams rgb raster frames
// through the edge filter, checks every edge pixel against its own model of the
// combined kernel or typed rows. depends on csef_pkg, csef_in_if, csef_out_if.

module tb_combined_sobel_edge_filter;

  localparam int CLK_HALF      = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_SLACK     = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int MODE_ITEMS    = 450;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } edge_px_t;

  // 3x3 neighborhood, entry c*3+r: column dx = c-1, row dy = r-1
  typedef logic [8:0][23:0] nbhd_t;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} dir_kind_t;

  typedef struct packed {
    dir_kind_t                     kind;
    csef_pkg::cfg_reg_t            reg_sel;
    logic [csef_pkg::CFG_BITS-1:0] reg_val;
    logic [7:0]                    red;
    logic [7:0]                    green;
    logic [7:0]                    blue;
    logic                          pad;
    logic                          typed;
    edge_px_t                      want;
  } dir_row_t;

  localparam edge_px_t EDGE_NONE = '0;
  localparam edge_px_t EDGE_SAT  = {8'hff, 8'hff, 8'hff, 1'b0};
  localparam edge_px_t EDGE_END  = {24'h0, 1'b1};

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          wr_en;
  csef_pkg::cfg_reg_t            wr_index;
  logic [csef_pkg::CFG_BITS-1:0] wr_data;

  csef_in_if  pixels_if ();
  csef_out_if edges_if ();

  combined_sobel_edge_filter u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pixels   (pixels_if),
    .edges    (edges_if)
  );

  always #CLK_HALF clk = ~clk;

  int send_idle_pct = 27;
  int recv_idle_pct = 66;
  int failures      = 0;
  int cycle_count   = 0;
  int random_items  = 0;

  logic     typed_valid = 1'b0;
  edge_px_t typed_px    = '0;

  // filter model state
  logic [csef_pkg::CFG_BITS-1:0] cfg_width  = csef_pkg::CFG_BITS'(csef_pkg::WIDTH_RESET);
  logic [csef_pkg::CFG_BITS-1:0] cfg_height = csef_pkg::CFG_BITS'(csef_pkg::HEIGHT_RESET);
  logic [23:0]                   line_near [csef_pkg::MAX_WIDTH];
  logic [23:0]                   line_far  [csef_pkg::MAX_WIDTH];
  nbhd_t                         win_pix    = '0;
  int                            col_pos    = 0;
  int                            row_pos    = 0;

  edge_px_t pending_edges [$];
  dir_row_t directed_rows [$];

  function automatic int eff_width();
    int w;
    w = cfg_width;
    if (w < 1) w = 1;
    if (w > csef_pkg::MAX_WIDTH) w = csef_pkg::MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = cfg_height;
    if (h < 1) h = 1;
    if (h > csef_pkg::HEIGHT_LIMIT) h = csef_pkg::HEIGHT_LIMIT;
    return h;
  endfunction

  function automatic edge_px_t combined_kernel(input nbhd_t nb, input int cx, input int cy,
                                               input int w, input int h);
    int acc [0:2];
    int c, r, k, nx, ny, s, wt, v;
    logic [23:0] outv;
    edge_px_t res;
    for (k = 0; k < 3; k++) acc[k] = 0;
    for (c = 0; c < 3; c++) begin
      for (r = 0; r < 3; r++) begin
        nx = cx + c - 1;
        ny = cy + r - 1;
        s  = (c - 1) + (r - 1);
        wt = (s > 0) ? 2 : ((s < 0) ? -2 : 0);
        if (nx >= 0 && nx < w && ny >= 0 && ny < h && wt != 0) begin
          for (k = 0; k < 3; k++) acc[k] += wt * int'(nb[c*3+r][k*8 +: 8]);
        end
      end
    end
    outv = '0;
    for (k = 0; k < 3; k++) begin
      v = acc[k];
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      outv[k*8 +: 8] = v[7:0];
    end
    res.red       = outv[7:0];
    res.green     = outv[15:8];
    res.blue      = outv[23:16];
    res.frame_end = (cx == w - 1 && cy == h - 1);
    return res;
  endfunction

  task automatic predict_edges(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic pad_bit, output logic produced,
                               output edge_px_t res);
    int w, h, cx, cy, i;
    logic [23:0] px, far_px, near_px;
    nbhd_t nb;
    w = eff_width();
    h = eff_height();
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > h + 1) row_pos = 0;
    cx = col_pos;
    cy = row_pos;
    px = pad_bit ? 24'h0 : {b, g, r};
    produced = 1'b0;
    res = '0;
    // last column of the row two above: right neighbors lie outside
    if (cx == 0 && cy >= 2) begin
      nb = '0;
      for (i = 0; i < 6; i++) nb[i] = win_pix[i+3];
      res = combined_kernel(nb, w - 1, cy - 2, w, h);
      produced = 1'b1;
    end
    far_px  = line_far[cx];
    near_px = line_near[cx];
    line_far[cx]  = near_px;
    line_near[cx] = px;
    for (i = 0; i < 6; i++) win_pix[i] = win_pix[i+3];
    win_pix[6] = far_px;
    win_pix[7] = near_px;
    win_pix[8] = px;
    if (cx != 0 && cy >= 1 && cy <= h) begin
      res = combined_kernel(win_pix, cx - 1, cy - 1, w, h);
      produced = 1'b1;
    end
    if (cx + 1 >= w) begin
      col_pos = 0;
      row_pos = cy + 1;
    end else begin
      col_pos = cx + 1;
    end
    if (cx == 0 && cy == h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  task automatic check_edge(input edge_px_t got);
    edge_px_t want;
    if (pending_edges.size() == 0) begin
      $error("edge pixel arrived with none predicted");
      failures++;
    end else begin
      want = pending_edges.pop_front();
      check_field("red_out", want.red, got.red);
      check_field("green_out", want.green, got.green);
      check_field("blue_out", want.blue, got.blue);
      check_field("frame_end", {7'd0, want.frame_end}, {7'd0, got.frame_end});
    end
  endtask

  always @(posedge clk) begin : monitor
    logic     produced;
    edge_px_t predicted;
    if (!rst) begin
      if (wr_en) begin
        case (wr_index)
          csef_pkg::REG_IMAGE_WIDTH:  cfg_width = wr_data;
          csef_pkg::REG_IMAGE_HEIGHT: cfg_height = wr_data;
          default: ;
        endcase
      end
      if (pixels_if.valid && pixels_if.ready) begin
        predict_edges(pixels_if.red_in, pixels_if.green_in, pixels_if.blue_in, pixels_if.pad,
                      produced, predicted);
        if (produced) pending_edges.push_back(typed_valid ? typed_px : predicted);
      end
      if (edges_if.valid && edges_if.ready)
        check_edge({edges_if.red_out, edges_if.green_out, edges_if.blue_out,
                    edges_if.frame_end});
    end
  end

  always @(negedge clk) begin
    edges_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic pad_bit, input logic typed, input edge_px_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      pixels_if.valid <= 1'b0;
      @(negedge clk);
    end
    pixels_if.valid    <= 1'b1;
    pixels_if.red_in   <= r;
    pixels_if.green_in <= g;
    pixels_if.blue_in  <= b;
    pixels_if.pad      <= pad_bit;
    typed_valid        <= typed;
    typed_px           <= want;
    @(posedge clk);
    while (!pixels_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_edges();
    pixels_if.valid <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input csef_pkg::cfg_reg_t sel,
                           input logic [csef_pkg::CFG_BITS-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= sel;
    wr_data  <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [csef_pkg::CFG_BITS-1:0] w,
                              input logic [csef_pkg::CFG_BITS-1:0] h);
    drain_edges();
    write_reg(csef_pkg::REG_IMAGE_WIDTH, w);
    write_reg(csef_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // next pixel in raster order; pad flag follows the region unless noisy
  task automatic send_raster_pixel(input logic noisy);
    int w, h, cy;
    logic pad_bit;
    w  = eff_width();
    h  = eff_height();
    cy = row_pos;
    if (col_pos >= w) cy++;
    if (cy > h + 1) cy = 0;
    if (noisy && $urandom_range(9) == 0) pad_bit = 1'($urandom_range(1));
    else pad_bit = (cy >= h);
    send_pixel(rand_channel(), rand_channel(), rand_channel(), pad_bit, 1'b0, EDGE_NONE);
    random_items++;
  endtask

  task automatic run_frame(input logic noisy);
    send_raster_pixel(noisy);
    while (col_pos != 0 || row_pos != 0) send_raster_pixel(noisy);
  endtask

  task automatic add_write(input csef_pkg::cfg_reg_t sel,
                           input logic [csef_pkg::CFG_BITS-1:0] val);
    dir_row_t row;
    row = '0;
    row.kind    = ROW_WRITE;
    row.reg_sel = sel;
    row.reg_val = val;
    directed_rows.push_back(row);
  endtask

  task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic pad_bit, input logic typed, input edge_px_t want);
    dir_row_t row;
    row = '0;
    row.kind  = ROW_PIXEL;
    row.red   = r;
    row.green = g;
    row.blue  = b;
    row.pad   = pad_bit;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  initial begin : stimulus
    int i, mode, mark;
    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = csef_pkg::REG_IMAGE_WIDTH;
    wr_data            = '0;
    pixels_if.valid    = 1'b0;
    pixels_if.red_in   = '0;
    pixels_if.green_in = '0;
    pixels_if.blue_in  = '0;
    pixels_if.pad      = 1'b0;
    edges_if.ready     = 1'b0;
    for (i = 0; i < csef_pkg::MAX_WIDTH; i++) begin
      line_near[i] = '0;
      line_far[i]  = '0;
    end

    // 2x2 frame of full white
    add_write(csef_pkg::REG_IMAGE_WIDTH, 12'd2);
    add_write(csef_pkg::REG_IMAGE_HEIGHT, 12'd2);
    add_pixel(8'hff, 8'hff, 8'hff, 1'b0, 1'b0, EDGE_NONE);
    add_pixel(8'hff, 8'hff, 8'hff, 1'b0, 1'b0, EDGE_NONE);
    add_pixel(8'hff, 8'hff, 8'hff, 1'b0, 1'b0, EDGE_NONE);
    add_pixel(8'hff, 8'hff, 8'hff, 1'b0, 1'b1, EDGE_SAT);
    add_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, EDGE_NONE);
    add_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, EDGE_NONE);
    add_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, EDGE_END);
    // zero geometry behaves as a single pixel
    add_write(csef_pkg::REG_IMAGE_WIDTH, 12'd0);
    add_write(csef_pkg::REG_IMAGE_HEIGHT, 12'd0);
    add_pixel(8'hff, 8'h00, 8'hff, 1'b0, 1'b0, EDGE_NONE);
    add_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, EDGE_NONE);
    add_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, EDGE_END);
    // 3x2 with a pad inside the frame and live pixels in the pad rows
    add_write(csef_pkg::REG_IMAGE_WIDTH, 12'd3);
    add_write(csef_pkg::REG_IMAGE_HEIGHT, 12'd2);
    add_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, EDGE_NONE);
    add_pixel(8'hff, 8'hff, 8'hff, 1'b0, 1'b0, EDGE_NONE);
    add_pixel(8'hff, 8'h00, 8'h80, 1'b0, 1'b0, EDGE_NONE);
    add_pixel(8'h11, 8'hc8, 8'h03, 1'b1, 1'b0, EDGE_NONE);
    add_pixel(8'hff, 8'hff, 8'hff, 1'b0, 1'b0, EDGE_NONE);
    add_pixel(8'h01, 8'h02, 8'h03, 1'b0, 1'b0, EDGE_NONE);
    add_pixel(8'h09, 8'h09, 8'h09, 1'b1, 1'b0, EDGE_NONE);
    add_pixel(8'hff, 8'hff, 8'hff, 1'b0, 1'b0, EDGE_NONE);
    add_pixel(8'h04, 8'h05, 8'h06, 1'b1, 1'b0, EDGE_NONE);
    add_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, EDGE_NONE);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[j]) begin
      if (directed_rows[j].kind == ROW_WRITE) begin
        drain_edges();
        write_reg(directed_rows[j].reg_sel, directed_rows[j].reg_val);
      end else begin
        send_pixel(directed_rows[j].red, directed_rows[j].green, directed_rows[j].blue,
                   directed_rows[j].pad, directed_rows[j].typed, directed_rows[j].want);
      end
    end

    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 27 : ((mode == 1) ? 66 : 0);
      recv_idle_pct = (mode == 0) ? 66 : ((mode == 1) ? 27 : 0);
      if (mode == 1) begin
        // height above the limit, left in the middle of the frame
        set_geometry(12'd2, 12'd4095);
        repeat (30) send_raster_pixel(1'b0);
      end
      if (mode == 2) begin
        // width above the limit, then geometry shrinks in the middle of a frame
        set_geometry(12'd4095, 12'd1);
        repeat (40) send_raster_pixel(1'b0);
        set_geometry(12'd8, 12'd6);
        run_frame(1'b0);
        repeat (22) send_raster_pixel(1'b0);
        set_geometry(12'd5, 12'd1);
        run_frame(1'b0);
      end
      mark = random_items;
      while (random_items - mark < MODE_ITEMS) begin
        set_geometry(12'($urandom_range(1, 14)), 12'($urandom_range(1, 9)));
        repeat ($urandom_range(1, 3)) run_frame($urandom_range(4) == 0);
      end
    end

    drain_edges();
    repeat (END_SLACK) @(negedge clk);
    if (failures == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
